/* hdl/dttn_pkg.sv */
// Shared types and constants for the duration text to nanoseconds parser.
// Used by the channel interfaces, the byte scanner, the scaler and the top level.
`timescale 1ns / 1ps

package dttn_pkg;

   localparam int CHAR_W     = 8;
   localparam int NS_W       = 64;
   localparam int STATUS_W   = 2;
   localparam int UNIT_COUNT = 8;

   typedef enum logic [2:0] {
      PH_START,
      PH_SIGN,
      PH_DIGITS,
      PH_UNIT,
      PH_BAD,
      PH_ZERO
   } phase_type;

   typedef enum logic [2:0] {
      UNIT_NONE,
      UNIT_SEC,
      UNIT_MIN,
      UNIT_HOUR,
      UNIT_DAY,
      UNIT_WEEK,
      UNIT_YEAR
   } unit_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_MALFORMED,
      ST_RANGE
   } status_type;

   // What the scanner concluded about a finished string.
   typedef enum logic [1:0] {
      KIND_KEYWORD,
      KIND_BAD,
      KIND_RANGE,
      KIND_SCALE
   } kind_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } text_byte_type;

   typedef struct packed {
      kind_type          kind;
      unit_type          unit;
      logic [NS_W-1:0]   number;
   } record_type;

endpackage

/* hdl/dttn_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on dttn_pkg for field widths.
`timescale 1ns / 1ps

interface dttn_req_if;
   import dttn_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface dttn_rsp_if;
   import dttn_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NS_W-1:0]     duration_ns;

   modport source (output valid, output status, output duration_ns, input ready);
   modport sink   (input valid, input status, input duration_ns, output ready);
endinterface

/* hdl/dttn_scan.sv */
// Byte scanner: keyword matcher, sign/digit/unit parser and 64-bit decimal accumulator.
// Depends on dttn_pkg. Emits one record per string on the last byte.
`timescale 1ns / 1ps

module dttn_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  dttn_pkg::text_byte_type byte_in,
   output logic                   byte_ready,
   output logic                   rec_valid,
   input  logic                   rec_ready,
   output dttn_pkg::record_type   rec
);
   import dttn_pkg::*;

   localparam int KW_COUNT = 3;
   localparam logic [7:0][7:0] KW_TEXT [KW_COUNT] = '{"infinite", "never", "forever"};
   localparam logic [3:0]      KW_LEN  [KW_COUNT] = '{4'd8, 4'd5, 4'd7};
   localparam logic [3:0]      POS_MAX = 4'd15;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_DIG0  = "0";
   localparam logic [7:0] CH_DIG9  = "9";
   localparam logic [7:0] CH_UPA   = "A";
   localparam logic [7:0] CH_UPZ   = "Z";
   localparam logic [7:0] CASE_BIT = 8'h20;
   localparam logic [7:0] CH_SEC   = "s";
   localparam logic [7:0] CH_MIN   = "m";
   localparam logic [7:0] CH_HOUR  = "h";
   localparam logic [7:0] CH_DAY   = "d";
   localparam logic [7:0] CH_WEEK  = "w";
   localparam logic [7:0] CH_YEAR  = "y";

   function automatic logic kw_match(input logic [7:0][7:0] text, input logic [3:0] len,
                                     input logic [3:0] pos, input logic [7:0] ch);
      logic [3:0] idx;
      idx = len - pos - 4'd1;
      return (pos < len) && (text[idx[2:0]] == ch);
   endfunction

   function automatic unit_type unit_of(input logic [7:0] ch);
      unit_type u;
      unique case (ch)
         CH_SEC:  u = UNIT_SEC;
         CH_MIN:  u = UNIT_MIN;
         CH_HOUR: u = UNIT_HOUR;
         CH_DAY:  u = UNIT_DAY;
         CH_WEEK: u = UNIT_WEEK;
         CH_YEAR: u = UNIT_YEAR;
         default: u = UNIT_NONE;
      endcase
      return u;
   endfunction

   phase_type           phase_ff, phase_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;
   logic [3:0]          pos_ff, pos_in;
   logic [NS_W-1:0]     acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic                seen_ff, seen_in;
   unit_type            unit_ff, unit_in;

   logic [7:0]      ch;
   logic [7:0]      lc;
   logic            is_digit;
   logic            take;
   logic            kw_hit;
   logic            fire;
   logic [NS_W+3:0] digit_wide;

   assign ch       = byte_in.char_code;
   assign lc       = (ch >= CH_UPA && ch <= CH_UPZ) ? (ch | CASE_BIT) : ch;
   assign is_digit = (ch >= CH_DIG0) && (ch <= CH_DIG9);
   // acc * 10 + digit, with four spare bits to see the carry out
   assign digit_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                       {(NS_W + 0)'(0), ch[3:0]};

   assign byte_ready = !byte_in.last || rec_ready;
   assign fire       = byte_valid && byte_ready;
   assign pos_in     = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 4'd1;

   always_comb begin
      alive_in = '0;
      kw_hit   = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         alive_in[k] = alive_ff[k] && kw_match(KW_TEXT[k], KW_LEN[k], pos_ff, lc);
         if (alive_in[k] && (pos_ff + 4'd1 == KW_LEN[k])) begin
            kw_hit = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      unit_in  = unit_ff;
      take     = 1'b0;
      if (ch == CH_NUL) begin
         phase_in = PH_ZERO;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (ch == CH_PLUS) phase_in = PH_SIGN;
               else if (is_digit) take = 1'b1;
               else phase_in = PH_BAD;
            end
            PH_SIGN: begin
               if (is_digit) take = 1'b1;
               else phase_in = PH_BAD;
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  take = 1'b1;
               end else begin
                  unit_in  = unit_of(ch);
                  phase_in = (unit_in != UNIT_NONE) ? PH_UNIT : PH_BAD;
               end
            end
            PH_UNIT: phase_in = PH_BAD;
            default: phase_in = phase_ff;
         endcase
      end
      if (take) begin
         if (!ovf_ff) begin
            if (digit_wide[NS_W+3:NS_W] != 4'd0) ovf_in = 1'b1;
            else acc_in = digit_wide[NS_W-1:0];
         end
         seen_in  = 1'b1;
         phase_in = PH_DIGITS;
      end
   end

   always_comb begin
      rec_valid  = byte_valid && byte_in.last;
      rec.unit   = unit_in;
      rec.number = acc_in;
      if (kw_hit) rec.kind = KIND_KEYWORD;
      else if (phase_in == PH_ZERO) rec.kind = KIND_BAD;
      else if (ovf_in) rec.kind = KIND_RANGE;
      else if (phase_in == PH_UNIT && seen_in && unit_in != UNIT_NONE) rec.kind = KIND_SCALE;
      else rec.kind = KIND_BAD;
   end

   // State returns to its start values after every last byte.
   always_ff @(posedge clock) begin
      if (reset || (fire && byte_in.last)) begin
         phase_ff <= PH_START;
         alive_ff <= '1;
         pos_ff   <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         unit_ff  <= UNIT_NONE;
      end else if (fire) begin
         phase_ff <= phase_in;
         alive_ff <= alive_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         unit_ff  <= unit_in;
      end
   end

endmodule

/* hdl/dttn_scale.sv */
// Scaler: range check and number * unit * 1e9 over two register stages, plus the
// response register. Depends on dttn_pkg and the response channel interface.
`timescale 1ns / 1ps

module dttn_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rec_valid,
   output logic                 rec_ready,
   input  dttn_pkg::record_type rec,
   dttn_rsp_if.source           rsp_if
);
   import dttn_pkg::*;

   localparam int HALF_W   = NS_W / 2;
   // Largest number that survives the range check is below 2**35.
   localparam int NUM_HI_W = 3;

   // Nanoseconds per unit.
   localparam logic [NS_W-1:0] UNIT_NS [UNIT_COUNT] = '{
      64'd0,
      64'd1_000_000_000,
      64'd60_000_000_000,
      64'd3_600_000_000_000,
      64'd86_400_000_000_000,
      64'd604_800_000_000_000,
      64'd31_536_000_000_000_000,
      64'd0
   };
   // Largest number whose product with the unit fits in 64 bits.
   localparam logic [NS_W-1:0] UNIT_LIMIT [UNIT_COUNT] = '{
      64'd0,
      64'd18_446_744_073,
      64'd307_445_734,
      64'd5_124_095,
      64'd213_503,
      64'd30_500,
      64'd584,
      64'd0
   };

   logic en2, en3, en4;

   logic       s2_valid_ff;
   record_type s2_rec_ff;

   logic              s3_valid_ff;
   status_type        s3_status_ff, s3_status_in;
   logic              s3_scaled_ff, s3_scaled_in;
   logic [NS_W-1:0]   p0_ff, p0_in;
   logic [HALF_W-1:0] p1_ff, p1_in;
   logic [HALF_W-1:0] p2_ff, p2_in;

   logic            rsp_valid_ff;
   status_type      status_ff;
   logic [NS_W-1:0] ns_ff, ns_in;

   logic [NS_W-1:0]     unit_ns;
   logic [HALF_W-1:0]   n_lo, c_lo, c_hi;
   logic [NUM_HI_W-1:0] n_hi;
   logic [HALF_W-1:0]   cross_sum;

   assign en4       = !rsp_valid_ff || rsp_if.ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign rec_ready = en2;

   assign unit_ns = UNIT_NS[s2_rec_ff.unit];
   assign n_lo    = s2_rec_ff.number[HALF_W-1:0];
   assign n_hi    = s2_rec_ff.number[HALF_W+NUM_HI_W-1:HALF_W];
   assign c_lo    = unit_ns[HALF_W-1:0];
   assign c_hi    = unit_ns[NS_W-1:HALF_W];

   // The high-by-high product lands entirely above bit 63 and is dropped.
   assign p0_in = NS_W'(n_lo) * NS_W'(c_lo);
   assign p1_in = n_lo * c_hi;
   assign p2_in = HALF_W'(n_hi) * c_lo;

   always_comb begin
      s3_scaled_in = 1'b0;
      case (s2_rec_ff.kind)
         KIND_KEYWORD: s3_status_in = ST_OK;
         KIND_RANGE:   s3_status_in = ST_RANGE;
         KIND_SCALE: begin
            if (s2_rec_ff.number > UNIT_LIMIT[s2_rec_ff.unit]) begin
               s3_status_in = ST_RANGE;
            end else begin
               s3_status_in = ST_OK;
               s3_scaled_in = 1'b1;
            end
         end
         default:      s3_status_in = ST_MALFORMED;
      endcase
   end

   assign cross_sum = p1_ff + p2_ff;
   assign ns_in     = s3_scaled_ff ? (p0_ff + {cross_sum, {HALF_W{1'b0}}}) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en2) s2_valid_ff <= rec_valid;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && rec_valid) s2_rec_ff <= rec;
      if (en3 && s2_valid_ff) begin
         s3_status_ff <= s3_status_in;
         s3_scaled_ff <= s3_scaled_in;
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
      end
      if (en4 && s3_valid_ff) begin
         status_ff <= s3_status_ff;
         ns_ff     <= ns_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.duration_ns = ns_ff;

endmodule

/* hdl/duration_text_to_nanoseconds.sv */
// Top level of the duration text to nanoseconds parser.
// Depends on dttn_pkg, dttn_ifs, dttn_scan and dttn_scale.
`timescale 1ns / 1ps
//
//   channel  direction  payload                          handshake
//   req_if   in         char_code[7:0], last             valid/ready
//   rsp_if   out        status[1:0], duration_ns[63:0]   valid/ready
//
// One request byte per cycle while rsp_if keeps up. Only the byte flagged last
// makes a response, registered at the input and after scan, multiply and sum.
// Synchronous active-high reset empties every stage and restarts the string state.
// Backpressure comes only from rsp_if: req_if.ready drops only when the response
// register holds an unaccepted response and every stage behind it is full.

module duration_text_to_nanoseconds (
   input logic       clock,
   input logic       reset,
   dttn_req_if.sink  req_if,
   dttn_rsp_if.source rsp_if
);
   import dttn_pkg::*;

   // Request register in front of the scanner.
   logic          in_valid_ff;
   text_byte_type in_byte_ff;

   logic       scan_ready;
   logic       rec_valid;
   logic       rec_ready;
   record_type rec;

   // Non-last bytes are always consumed; last bytes wait for room in the scaler.
   assign req_if.ready = !in_valid_ff || scan_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff.char_code <= req_if.char_code;
         in_byte_ff.last      <= req_if.last;
      end
   end

   dttn_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .byte_in    (in_byte_ff),
      .byte_ready (scan_ready),
      .rec_valid  (rec_valid),
      .rec_ready  (rec_ready),
      .rec        (rec)
   );

   dttn_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec),
      .rsp_if    (rsp_if)
   );

`ifndef NO_ASSERTIONS
   // Any response that is not ok carries a zero duration.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |-> (rsp_if.duration_ns == '0))
      else $error("non-ok response with nonzero duration");

   // Pipeline is empty and open right after reset.
   a_ready_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_if.ready)
      else $error("request side not ready after reset");

   // The request side only stalls behind a response that is being held off.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without response backpressure");
`endif

endmodule
